// ===== design/srrq_pkg.sv =====
package srrq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int PAYLOAD_BYTES   = 8;
  localparam int WORD_W          = 8 * PAYLOAD_BYTES;
  localparam int KEY_W           = 48;
  localparam int POS_W           = 4;

  localparam logic [7:0]       SYNC_RESET = 8'hFF;
  localparam logic [POS_W-1:0] POS_HUNT   = 4'd0;
  localparam logic [POS_W-1:0] POS_CHECK  = 4'd9;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_SEND = 1'b1;

  typedef enum logic [2:0] {
    ST_TAKEN    = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_BADCHECK = 3'd2,
    ST_FULL     = 3'd3,
    ST_SENT     = 3'd4,
    ST_EMPTY    = 3'd5,
    ST_BUSY     = 3'd6
  } status_t;

  // framer verdict for the current byte
  typedef struct packed {
    logic check_pos;
    logic check_ok;
  } frame_res_t;

  // request metadata waiting for the report memory read
  typedef struct packed {
    status_t status;
    logic    report_valid;
    logic    wake;
  } meta_t;

endpackage

// ===== design/srrq_framer.sv =====
module srrq_framer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        byte_en,
  input  logic [7:0]                  rx_byte,
  input  logic [7:0]                  sync_value,
  output srrq_pkg::frame_res_t        res,
  output logic [srrq_pkg::WORD_W-1:0] word
);

  logic [srrq_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]                 xor_r, xor_nxt;
  logic [7:0]                 payload_r [srrq_pkg::PAYLOAD_BYTES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= srrq_pkg::POS_HUNT;
      xor_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      xor_r <= xor_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < srrq_pkg::PAYLOAD_BYTES; i++) begin
      if (byte_en && pos_r == srrq_pkg::POS_W'(i + 1)) begin
        payload_r[i] <= rx_byte;
      end
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    xor_nxt       = xor_r;
    res.check_pos = byte_en && (pos_r >= srrq_pkg::POS_CHECK);
    res.check_ok  = (xor_r == rx_byte);
    if (byte_en) begin
      if (pos_r == srrq_pkg::POS_HUNT) begin
        if (rx_byte == sync_value) begin
          pos_nxt = srrq_pkg::POS_HUNT + srrq_pkg::POS_W'(1);
          xor_nxt = '0;
        end
      end else if (pos_r < srrq_pkg::POS_CHECK) begin
        pos_nxt = pos_r + srrq_pkg::POS_W'(1);
        xor_nxt = xor_r ^ rx_byte;
      end else begin
        pos_nxt = srrq_pkg::POS_HUNT;
      end
    end
  end

  // byte 1 in the low bits
  always_comb begin
    for (int i = 0; i < srrq_pkg::PAYLOAD_BYTES; i++) begin
      word[8*i +: 8] = payload_r[i];
    end
  end

endmodule

// ===== design/srrq_mem.sv =====
module srrq_mem #(
  parameter int DEPTH  = srrq_pkg::QUEUE_DEPTH_DEF,
  parameter int ADDR_W = 4
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [srrq_pkg::WORD_W-1:0] wr_data,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [srrq_pkg::WORD_W-1:0] rd_data
);

  logic [srrq_pkg::WORD_W-1:0] mem [DEPTH];
  logic [srrq_pkg::WORD_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/sync_frame_receiver_report_queue.sv =====
// Throughput: one request per cycle; the report memory read and the output
// register form a two-deep pipeline that stalls only on out_ready.
// Reset (synchronous, rst_n low): framer hunts for sync, queue indices zero,
// sync value 0xFF, pipeline empty. Report memory contents are not cleared.
module sync_frame_receiver_report_queue #(
  parameter int QUEUE_DEPTH = srrq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [7:0]                 cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_operation,
  input  logic [7:0]                 in_rx_byte,
  input  logic                       in_host_ready,
  input  logic                       in_host_suspended,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_status,
  output logic                       out_report_valid,
  output logic [7:0]                 out_modifier_bits,
  output logic [srrq_pkg::KEY_W-1:0] out_key_codes,
  output logic                       out_wake_request
);

  localparam int IDX_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  logic [7:0]       sync_value_r;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [IDX_W-1:0] rd_idx_inc;

  logic                        accept;
  logic                        byte_en;
  srrq_pkg::frame_res_t        fres;
  logic [srrq_pkg::WORD_W-1:0] frame_word;

  logic                        mem_we;
  logic                        mem_re;
  logic [srrq_pkg::WORD_W-1:0] mem_rd_data;

  srrq_pkg::meta_t s1_nxt;
  srrq_pkg::meta_t s1_r;
  logic            s1_valid_r;
  logic            s1_adv;

  logic                       out_valid_r;
  srrq_pkg::status_t          out_status_r;
  logic                       out_report_valid_r;
  logic [7:0]                 out_modifier_bits_r;
  logic [srrq_pkg::KEY_W-1:0] out_key_codes_r;
  logic                       out_wake_request_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;
  assign byte_en  = accept && (in_operation == srrq_pkg::OP_BYTE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_value_r <= srrq_pkg::SYNC_RESET;
    end else if (cfg_we) begin
      sync_value_r <= cfg_wdata;
    end
  end

  srrq_framer u_framer (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_en    (byte_en),
    .rx_byte    (in_rx_byte),
    .sync_value (sync_value_r),
    .res        (fres),
    .word       (frame_word)
  );

  srrq_mem #(
    .DEPTH  (QUEUE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (wr_idx_r[ADDR_W-1:0]),
    .wr_data (frame_word),
    .rd_en   (mem_re),
    .rd_addr (rd_idx_r[ADDR_W-1:0]),
    .rd_data (mem_rd_data)
  );

  assign rd_idx_inc = rd_idx_r + IDX_W'(1);

  always_comb begin
    wr_idx_nxt          = wr_idx_r;
    rd_idx_nxt          = rd_idx_r;
    mem_we              = 1'b0;
    mem_re              = 1'b0;
    s1_nxt.status       = srrq_pkg::ST_TAKEN;
    s1_nxt.report_valid = 1'b0;
    s1_nxt.wake         = 1'b0;
    if (accept) begin
      if (in_operation == srrq_pkg::OP_BYTE) begin
        if (fres.check_pos) begin
          if (!fres.check_ok) begin
            s1_nxt.status = srrq_pkg::ST_BADCHECK;
          end else if (wr_idx_r >= IDX_W'(QUEUE_DEPTH)) begin
            s1_nxt.status = srrq_pkg::ST_FULL;
          end else begin
            mem_we        = 1'b1;
            wr_idx_nxt    = wr_idx_r + IDX_W'(1);
            s1_nxt.status = srrq_pkg::ST_QUEUED;
          end
        end
      end else if (wr_idx_r == '0) begin
        s1_nxt.status = srrq_pkg::ST_EMPTY;
      end else begin
        s1_nxt.wake = in_host_suspended;
        if (!in_host_ready) begin
          s1_nxt.status = srrq_pkg::ST_BUSY;
        end else begin
          mem_re              = 1'b1;
          s1_nxt.status       = srrq_pkg::ST_SENT;
          s1_nxt.report_valid = 1'b1;
          // queue drained: start over at entry zero
          if (rd_idx_inc == wr_idx_r) begin
            rd_idx_nxt = '0;
            wr_idx_nxt = '0;
          end else begin
            rd_idx_nxt = rd_idx_inc;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      wr_idx_r <= wr_idx_nxt;
      rd_idx_r <= rd_idx_nxt;
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r       <= s1_r.status;
      out_report_valid_r <= s1_r.report_valid;
      out_wake_request_r <= s1_r.wake;
      if (s1_r.report_valid) begin
        out_modifier_bits_r <= mem_rd_data[7:0];
        out_key_codes_r     <= mem_rd_data[srrq_pkg::WORD_W-1:16];
      end else begin
        out_modifier_bits_r <= '0;
        out_key_codes_r     <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_report_valid  = out_report_valid_r;
  assign out_modifier_bits = out_modifier_bits_r;
  assign out_key_codes     = out_key_codes_r;
  assign out_wake_request  = out_wake_request_r;

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import srrq_pkg::*;

  localparam int DEPTH = QUEUE_DEPTH_DEF;

  typedef struct {
    status_t     status;
    bit          report_valid;
    bit [7:0]    modifier;
    bit [47:0]   keys;
    bit          wake;
  } report_t;

  // tracks framer and report queue state, holds the results still owed
  class report_scoreboard;
    bit [7:0]       sync_val;
    bit [POS_W-1:0] frame_pos;
    bit [7:0]       payload [PAYLOAD_BYTES];
    bit [63:0]      store [DEPTH];
    int unsigned    wr_idx;
    int unsigned    rd_idx;
    report_t        pending_q [$];
    int unsigned    errors;
    int unsigned    status_seen [7];

    function new();
      sync_val  = SYNC_RESET;
      frame_pos = POS_HUNT;
      wr_idx    = 0;
      rd_idx    = 0;
      errors    = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function void note_request(bit op, bit [7:0] rx, bit host_rdy, bit host_susp);
      report_t   r;
      bit [7:0]  sum;
      bit [63:0] word;
      r.status       = ST_TAKEN;
      r.report_valid = 1'b0;
      r.modifier     = 8'h00;
      r.keys         = 48'h0;
      r.wake         = 1'b0;
      if (op == OP_BYTE) begin
        if (frame_pos == POS_HUNT) begin
          if (rx == sync_val) frame_pos = 1;
        end else if (frame_pos < POS_CHECK) begin
          payload[frame_pos - 1] = rx;
          frame_pos++;
        end else begin
          frame_pos = POS_HUNT;
          sum = 8'h00;
          foreach (payload[i]) sum ^= payload[i];
          if (sum != rx) begin
            r.status = ST_BADCHECK;
          end else if (wr_idx >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            foreach (payload[i]) word[8*i +: 8] = payload[i];
            store[wr_idx] = word;
            wr_idx++;
            r.status = ST_QUEUED;
          end
        end
      end else if (wr_idx == 0) begin
        r.status = ST_EMPTY;
      end else begin
        r.wake = host_susp;
        if (!host_rdy) begin
          r.status = ST_BUSY;
        end else begin
          word = store[rd_idx];
          r.report_valid = 1'b1;
          r.modifier     = word[7:0];
          r.keys         = word[63:16];
          rd_idx++;
          if (rd_idx == wr_idx) begin
            rd_idx = 0;
            wr_idx = 0;
          end
          r.status = ST_SENT;
        end
      end
      status_seen[r.status]++;
      pending_q.push_back(r);
    endfunction

    task report(string field, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 40)
        $display("mismatch %0d at %0t: %s got %0h, want %0h", errors, $realtime, field,
                 got, want);
    endtask

    task check_result(logic [2:0] st, logic rv, logic [7:0] modi, logic [47:0] keys,
                      logic wake);
      report_t e;
      if (pending_q.size() == 0) begin
        report("unexpected result, status", st, 0);
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status)         report("status", st, e.status);
      if (rv !== e.report_valid)   report("report_valid", rv, e.report_valid);
      if (modi !== e.modifier)     report("modifier_bits", modi, e.modifier);
      if (keys !== e.keys)         report("key_codes", keys, e.keys);
      if (wake !== e.wake)         report("wake_request", wake, e.wake);
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [7:0]  in_rx_byte;
  logic        in_host_ready;
  logic        in_host_suspended;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_status;
  logic        out_report_valid;
  logic [7:0]  out_modifier_bits;
  logic [KEY_W-1:0] out_key_codes;
  logic        out_wake_request;

  report_scoreboard sb = new();
  int unsigned n_requests = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;

  sync_frame_receiver_report_queue uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_rx_byte        (in_rx_byte),
    .in_host_ready     (in_host_ready),
    .in_host_suspended (in_host_suspended),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_status        (out_status),
    .out_report_valid  (out_report_valid),
    .out_modifier_bits (out_modifier_bits),
    .out_key_codes     (out_key_codes),
    .out_wake_request  (out_wake_request)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", sb.pending_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: check on handshake, then pick ready for the next cycle
  always @(posedge clk) begin
    if (out_valid === 1'b1 && out_ready === 1'b1)
      sb.check_result(out_status, out_report_valid, out_modifier_bits, out_key_codes,
                      out_wake_request);
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 99) < 8) begin
      stall_left = $urandom_range(0, 9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_request(bit op, bit [7:0] rx, bit host_rdy, bit host_susp);
    if (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_operation      <= op;
    in_rx_byte        <= rx;
    in_host_ready     <= host_rdy;
    in_host_suspended <= host_susp;
    in_valid          <= 1'b1;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_request(op, rx, host_rdy, host_susp);
    n_requests++;
  endtask

  task automatic send_byte(bit [7:0] rx);
    send_request(OP_BYTE, rx, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_slots(int n);
    repeat (n)
      send_request(OP_SEND, 8'($urandom), 1'($urandom_range(0, 99) < 80),
                   1'($urandom_range(0, 99) < 25));
  endtask

  task automatic maybe_slots(int pct);
    if ($urandom_range(0, 99) < pct) send_slots($urandom_range(1, 4));
  endtask

  task automatic send_frame(bit [7:0] pl [PAYLOAD_BYTES], bit corrupt, int slot_pct);
    bit [7:0] chk;
    chk = 8'h00;
    foreach (pl[i]) chk ^= pl[i];
    if (corrupt) chk ^= 8'($urandom_range(1, 255));
    // realign: finish off any frame left open by noise
    while (sb.frame_pos != POS_HUNT) send_byte(8'($urandom));
    send_byte(sb.sync_val);
    foreach (pl[i]) begin
      maybe_slots(slot_pct);
      send_byte(pl[i]);
    end
    maybe_slots(slot_pct);
    send_byte(chk);
  endtask

  // waits out every owed result, then lets the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sync(bit [7:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.sync_val = v;
  endtask

  function automatic bit [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return sb.sync_val;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    bit [7:0]    pl [PAYLOAD_BYTES];
    int          send_pct;
    int unsigned phase_end;
    int          pick;
    in_valid          <= 1'b0;
    in_operation      <= OP_BYTE;
    in_rx_byte        <= 8'h00;
    in_host_ready     <= 1'b0;
    in_host_suspended <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_wdata         <= 8'h00;
    out_ready         <= 1'b0;
    rst_n             <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset sync value, empty/busy/sent slots, sync inside frame, bad check
    send_request(OP_SEND, 8'h00, 1'b1, 1'b1);
    send_byte(8'h00);
    send_byte(8'hFE);
    pl = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hFF, 8'h7F, 8'hFE, 8'h55};
    send_frame(pl, 1'b0, 0);
    send_request(OP_SEND, 8'h00, 1'b0, 1'b1);
    send_request(OP_SEND, 8'hFF, 1'b1, 1'b0);
    send_request(OP_SEND, 8'h00, 1'b1, 1'b0);
    pl = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC, 8'hDE, 8'hF0};
    send_frame(pl, 1'b1, 0);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0:       write_sync(8'h00);
        1:       write_sync(8'hFF);
        3:       write_sync(8'h5A);
        default: write_sync(8'($urandom));
      endcase
      // phase 0 barely sends, so the queue fills and frames get dropped
      case (phase)
        0:       send_pct = 3;
        2:       send_pct = 60;
        3:       send_pct = 15;
        default: send_pct = 35;
      endcase
      calm = (phase == 5);
      phase_end = n_requests + 300;
      while (n_requests < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          foreach (pl[i]) pl[i] = pick_byte();
          send_frame(pl, 1'($urandom_range(0, 99) < 12), send_pct / 4);
        end else if (pick < 80 && $urandom_range(0, 99) >= send_pct) begin
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
        end else if (pick < 88) begin
          // truncated frame, later bytes get absorbed into it
          while (sb.frame_pos != POS_HUNT) send_byte(8'($urandom));
          send_byte(sb.sync_val);
          repeat ($urandom_range(1, 8)) send_byte(pick_byte());
        end else if ($urandom_range(0, 99) < send_pct + 10) begin
          send_slots($urandom_range(1, 6));
        end else begin
          send_byte(8'($urandom));
        end
      end
    end

    drain();
    repeat (8) @(posedge clk);
    $display("%0d requests over 6 sync settings: %0d frames queued, %0d reports sent,",
             n_requests, sb.status_seen[ST_QUEUED], sb.status_seen[ST_SENT]);
    $display("%0d check failures, %0d full-queue drops, %0d busy and %0d empty slots",
             sb.status_seen[ST_BADCHECK], sb.status_seen[ST_FULL],
             sb.status_seen[ST_BUSY], sb.status_seen[ST_EMPTY]);
    if (sb.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/srrq_pkg.sv
design/srrq_framer.sv
design/srrq_mem.sv
design/sync_frame_receiver_report_queue.sv
test/tb.sv
